// ===== sv/dbspwm_pkg.sv =====
// shared types, constants and helpers for the deadband speed to pwm compare block
// no dependencies; imported by every module of the block
`default_nettype none

package dbspwm_pkg;

    // block sizing
    localparam int MOTORS       = 4;
    localparam int COMPARE_BITS = 16;
    localparam int MOTOR_W      = 2;
    localparam int COUNT_W      = 3;
    localparam int CMP_W        = 16;
    localparam int TABLE_W      = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int NUM_W        = 32;
    localparam int DEN_W        = 15;
    localparam int QUOT_W       = 16;

    localparam logic [CMP_W-1:0] CMP_MASK = CMP_W'((33'd1 << COMPARE_BITS) - 33'd1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DB_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DB_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSED = 3'd5;

    // command codes
    typedef enum logic [1:0] {
        ACT_SET_SPEED = 2'd0,
        ACT_STOP      = 2'd1,
        ACT_POWER_ON  = 2'd2,
        ACT_POWER_OFF = 2'd3
    } t_action;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_BAD_MOTOR = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PREP,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_POWER
    } t_state;

    // configuration register file contents
    typedef struct packed {
        logic [CMP_W-1:0]   period;
        logic [COUNT_W-1:0] count;
        logic [TABLE_W-1:0] db_low;
        logic [TABLE_W-1:0] neutral;
        logic [TABLE_W-1:0] db_high;
        logic [MOTORS-1:0]  reversed;
    } t_cfg;

    // divider handshake
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    // one 16-bit entry of a per-motor table
    function automatic logic [CMP_W-1:0] table_entry(input logic [TABLE_W-1:0] tbl,
                                                     input logic [MOTOR_W-1:0] m);
        return tbl[m*CMP_W +: CMP_W];
    endfunction

endpackage

`default_nettype wire

// ===== sv/dbspwm_cfg.sv =====
// configuration register file with reset values
// depends on dbspwm_pkg
`default_nettype none

module dbspwm_cfg
    import dbspwm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TABLE_W-1:0]   i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // register writes, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period   <= CMP_W'(1000);
            r_cfg.count    <= COUNT_W'(4);
            r_cfg.db_low   <= '0;
            r_cfg.neutral  <= '0;
            r_cfg.db_high  <= '0;
            r_cfg.reversed <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIOD:   r_cfg.period   <= i_cfg_data[CMP_W-1:0];
                CFG_COUNT:    r_cfg.count    <= i_cfg_data[COUNT_W-1:0];
                CFG_DB_LOW:   r_cfg.db_low   <= i_cfg_data;
                CFG_NEUTRAL:  r_cfg.neutral  <= i_cfg_data;
                CFG_DB_HIGH:  r_cfg.db_high  <= i_cfg_data;
                CFG_REVERSED: r_cfg.reversed <= i_cfg_data[MOTORS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/dbspwm_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on dbspwm_pkg; quotient must fit QUOT_W bits (high half of num below den)
`default_nettype none

module dbspwm_div
    import dbspwm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(QUOT_W);
    localparam int REM_W = NUM_W - QUOT_W;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [QUOT_W-1:0] r_q, n_q;
    logic [DEN_W-1:0] r_den, n_den;
    logic [REM_W:0]   w_trial;

    // one shift and conditional subtract per cycle
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_q     = r_q;
        n_den   = r_den;
        w_trial = {r_rem, r_q[QUOT_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_req.num[NUM_W-1:QUOT_W];
            n_q    = i_req.num[QUOT_W-1:0];
            n_den  = i_req.den;
        end else if (r_busy) begin
            if (w_trial >= (REM_W+1)'(r_den)) begin
                n_rem = REM_W'(w_trial - (REM_W+1)'(r_den));
                n_q   = {r_q[QUOT_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[REM_W-1:0];
                n_q   = {r_q[QUOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

`default_nettype wire

// ===== sv/deadband_speed_to_pwm_compare_top.sv =====
// motor command sequencer: speed to pwm compare with deadband, power sequencing
// depends on dbspwm_pkg, dbspwm_cfg, dbspwm_div
`default_nettype none

// A command is taken when start is high and busy is low; busy drops in the cycle
// that shows the command's last result. Each result is shown for one cycle with
// o_strobe high and cannot be held off. Stop, refused and invalid-motor commands
// show their result from the decode state, and a set-speed that clamps to zero
// from the clamp state. A set-speed with nonzero clamped speed steps through
// decode, clamp, multiply, a divider load, then the shared serial divider, one
// quotient bit per cycle, and the result. A power command emits one result per
// motor in use on successive cycles, or one empty result when none is in use.
module deadband_speed_to_pwm_compare_top
    import dbspwm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TABLE_W-1:0]   i_cfg_data,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_action,
    input  wire logic [MOTOR_W-1:0]   i_motor,
    input  wire logic signed [15:0]   i_speed,
    output logic                      o_strobe,
    output logic [MOTOR_W-1:0]        o_motor_out,
    output logic [CMP_W-1:0]          o_compare,
    output logic                      o_write_valid,
    output logic                      o_power_on,
    output logic [1:0]                o_status,
    output logic                      o_last
);

    t_cfg     w_cfg;
    t_div_req w_req;
    t_div_rsp w_rsp;

    t_state r_state, n_state;

    // command capture
    t_action           r_action, n_action;
    logic [MOTOR_W-1:0] r_motor, n_motor;
    logic [15:0]       r_speed, n_speed;

    // speed datapath
    logic [DEN_W-1:0]  r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [CMP_W-1:0]  r_span, n_span;
    logic [CMP_W-1:0]  r_base, n_base;
    logic [DEN_W-1:0]  r_full, n_full;
    logic [NUM_W-1:0]  r_num, n_num;

    // power sequencing
    logic              r_power, n_power;
    logic [MOTOR_W-1:0] r_idx, n_idx;

    // result registers
    logic              r_strobe, n_strobe;
    logic [MOTOR_W-1:0] r_mout, n_mout;
    logic [CMP_W-1:0]  r_cmp, n_cmp;
    logic              r_wv, n_wv;
    logic              r_pout, n_pout;
    t_status           r_status, n_status;
    logic              r_last, n_last;

    // derived values
    logic [COUNT_W-1:0] w_used;
    logic               w_bad_motor;
    logic               w_new_power;
    logic               w_idx_last;
    logic [15:0]        w_abs;
    logic [DEN_W-1:0]   w_cmax;
    logic [DEN_W-1:0]   w_mag;
    logic               w_neg;
    logic [CMP_W-1:0]   w_high;
    logic [CMP_W-1:0]   w_low;
    logic [NUM_W-1:0]   w_prod;

    dbspwm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    dbspwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // motor count saturated to the motors the block has
    assign w_used = (w_cfg.count > COUNT_W'(MOTORS)) ? COUNT_W'(MOTORS) : w_cfg.count;
    assign w_bad_motor = (COUNT_W'(r_motor) >= w_used);
    assign w_new_power = (r_action == ACT_POWER_ON);
    assign w_idx_last  = (COUNT_W'(r_idx) + COUNT_W'(1) == w_used);

    // clamp to half period, reversal flips the sign
    assign w_abs  = r_speed[15] ? 16'(~r_speed + 16'd1) : r_speed;
    assign w_cmax = w_cfg.period[CMP_W-1:1];
    assign w_mag  = (w_abs > 16'(w_cmax)) ? w_cmax : w_abs[DEN_W-1:0];
    assign w_neg  = r_speed[15] ^ w_cfg.reversed[r_motor];
    assign w_high = table_entry(w_cfg.db_high, r_motor);
    assign w_low  = table_entry(w_cfg.db_low, r_motor);

    // magnitude times span, rounded up by adding full scale minus one
    assign w_prod = NUM_W'(r_mag) * NUM_W'(r_span);

    assign w_req.start = (r_state == S_DSTART);
    assign w_req.num   = r_num;
    assign w_req.den   = r_full;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (r_action == ACT_POWER_ON || r_action == ACT_POWER_OFF) begin
                    n_state = (w_used == '0) ? S_IDLE : S_POWER;
                end else if (w_bad_motor || r_action == ACT_STOP || !r_power) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = (w_mag == '0) ? S_IDLE : S_MUL;
            end
            S_MUL:    n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV: begin
                if (w_rsp.done) n_state = S_IDLE;
            end
            S_POWER: begin
                if (w_idx_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result values
    always_comb begin
        n_action = r_action;
        n_motor  = r_motor;
        n_speed  = r_speed;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_span   = r_span;
        n_base   = r_base;
        n_full   = r_full;
        n_num    = r_num;
        n_power  = r_power;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_mout   = r_mout;
        n_cmp    = r_cmp;
        n_wv     = r_wv;
        n_pout   = r_pout;
        n_status = r_status;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_action = t_action'(i_action);
                    n_motor  = i_motor;
                    n_speed  = i_speed;
                end
            end
            S_DECODE: begin
                n_idx  = '0;
                n_mout = r_motor;
                n_pout = r_power;
                n_last = 1'b1;
                if (r_action == ACT_POWER_ON || r_action == ACT_POWER_OFF) begin
                    // no motors in use: one empty result that takes the new level
                    if (w_used == '0) begin
                        n_strobe = 1'b1;
                        n_mout   = '0;
                        n_cmp    = '0;
                        n_wv     = 1'b0;
                        n_status = ST_OK;
                        n_pout   = w_new_power;
                        n_power  = w_new_power;
                    end
                end else if (w_bad_motor) begin
                    n_strobe = 1'b1;
                    n_cmp    = '0;
                    n_wv     = 1'b0;
                    n_status = ST_BAD_MOTOR;
                end else if (r_action == ACT_STOP) begin
                    n_strobe = 1'b1;
                    n_cmp    = table_entry(w_cfg.neutral, r_motor) & CMP_MASK;
                    n_wv     = 1'b1;
                    n_status = ST_OK;
                end else if (!r_power) begin
                    n_strobe = 1'b1;
                    n_cmp    = '0;
                    n_wv     = 1'b0;
                    n_status = ST_NOT_READY;
                end
            end
            S_PREP: begin
                n_mag    = w_mag;
                n_neg    = w_neg;
                n_full   = w_cmax;
                n_wv     = 1'b1;
                n_status = ST_OK;
                if (w_neg) begin
                    n_base = w_low;
                    n_span = w_low;
                end else begin
                    n_base = w_high;
                    n_span = (w_cfg.period > w_high) ? CMP_W'(w_cfg.period - w_high) : '0;
                end
                // zero clamped speed goes straight to neutral
                if (w_mag == '0) begin
                    n_strobe = 1'b1;
                    n_cmp    = table_entry(w_cfg.neutral, r_motor) & CMP_MASK;
                end
            end
            S_MUL: begin
                n_num = w_prod + NUM_W'(r_full) - NUM_W'(1);
            end
            S_DSTART: begin
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    n_strobe = 1'b1;
                    n_cmp    = (r_neg ? CMP_W'(r_base - w_rsp.quot)
                                      : CMP_W'(r_base + w_rsp.quot)) & CMP_MASK;
                end
            end
            S_POWER: begin
                // neutral to each motor in order, flag changes with the last one
                n_strobe = 1'b1;
                n_mout   = r_idx;
                n_cmp    = table_entry(w_cfg.neutral, r_idx) & CMP_MASK;
                n_wv     = 1'b1;
                n_status = ST_OK;
                n_last   = w_idx_last;
                n_pout   = w_idx_last ? w_new_power : r_power;
                n_idx    = r_idx + MOTOR_W'(1);
                if (w_idx_last) n_power = w_new_power;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_power  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_power  <= n_power;
            r_strobe <= n_strobe;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_motor  <= n_motor;
        r_speed  <= n_speed;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_span   <= n_span;
        r_base   <= n_base;
        r_full   <= n_full;
        r_num    <= n_num;
        r_idx    <= n_idx;
        r_mout   <= n_mout;
        r_cmp    <= n_cmp;
        r_wv     <= n_wv;
        r_pout   <= n_pout;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_motor_out   = r_mout;
    assign o_compare     = r_cmp;
    assign o_write_valid = r_wv;
    assign o_power_on    = r_pout;
    assign o_status      = r_status;
    assign o_last        = r_last;

endmodule

`default_nettype wire
